// ===== design/srs_pkg.sv =====
// Shared types and constants for the stable record sorter.
// Holds the transaction payload structs, the per-cell record type and the state enum.
// No dependencies.
package srs_pkg;

  // Field widths fixed by the record format.
  localparam int unsigned KeyBits = 64;
  localparam int unsigned IdBits  = 10;

  // Default capacity of the insertion chain.
  localparam int unsigned MaxRecordsDefault = 64;

  // Input transaction payload.
  typedef struct packed {
    logic [KeyBits-1:0] sort_key;
    logic [IdBits-1:0]  record_id;
    logic               last_record;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [KeyBits-1:0] sorted_key;
    logic [IdBits-1:0]  sorted_id;
    logic               last_out;
    logic               overflowed;
  } out_t;

  // Contents of one sorting cell.
  typedef struct packed {
    logic               vld;
    logic [KeyBits-1:0] key;
    logic [IdBits-1:0]  id;
  } cell_rec_t;

  // Control phases of the sorter.
  typedef enum logic [0:0] {
    StLoad,
    StDrain
  } state_e;

endpackage

// ===== design/srs_cell.sv =====
// One insertion cell of the sorting chain.
// Holds one record; depends on srs_pkg for the record type.
module srs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srs_pkg::cell_rec_t new_i,
  input  logic              ins_i,
  input  logic              shl_i,
  input  srs_pkg::cell_rec_t left_rec_i,
  input  logic              left_gt_i,
  input  srs_pkg::cell_rec_t right_rec_i,
  output srs_pkg::cell_rec_t rec_o,
  output logic              gt_o
);

  srs_pkg::cell_rec_t rec_q, rec_d;
  logic                        vld_q;
  logic [srs_pkg::KeyBits-1:0] key_q;
  logic [srs_pkg::IdBits-1:0]  id_q;

  assign rec_q = {vld_q, key_q, id_q};

  // An empty cell acts as an infinite key, so new records land in the first free cell.
  // Equal keys do not count as greater, which keeps load order among equal keys.
  assign gt_o = !rec_q.vld || (new_i.key < rec_q.key);

  // Insertion moves this cell's record one place right when the new key is smaller;
  // draining moves every record one place left.
  always_comb begin
    rec_d = rec_q;
    if (shl_i) begin
      rec_d = right_rec_i;
    end else if (ins_i && gt_o) begin
      if (left_gt_i) begin
        rec_d = left_rec_i;
      end else begin
        rec_d = new_i;
      end
    end
  end

  // The occupancy flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= rec_d.vld;
    end
  end

  // Key and id are payload and need no reset.
  always_ff @(posedge clk_i) begin
    key_q <= rec_d.key;
    id_q  <= rec_d.id;
  end

  assign rec_o = rec_q;

endmodule

// ===== design/stable_record_sorter_unit.sv =====
// Top level of the stable record sorter: a chain of insertion cells plus load/drain control.
// Depends on srs_pkg and srs_cell.
//
//   channel | signals                              | direction
//   input   | in_valid_i, in_ready_o, in_data_i    | records in load order
//   output  | out_valid_o, out_ready_i, out_data_o | records in ascending stable key order
//
// While loading, each accepted record is inserted into the cell chain at once; a record that
// finds the chain full is dropped and the set is flagged. After the record marked last, the set
// drains at one record per cycle through the output register while out_ready_i allows it.
// Input is held off while a set drains; output stalls only pause the drain.
// Reset empties the chain and clears the count and the overflow flag; no clearing pass.
module stable_record_sorter_unit #(
  parameter int unsigned MAX_RECORDS = srs_pkg::MaxRecordsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  srs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srs_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  srs_pkg::state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            out_vld_q, out_vld_d;
  srs_pkg::out_t   out_q, out_d;

  logic            in_acc;
  logic            full;
  logic            ins;
  logic            pop;
  logic            drain_done;
  srs_pkg::cell_rec_t new_rec;

  srs_pkg::cell_rec_t cell_rec [MAX_RECORDS];
  logic               cell_gt  [MAX_RECORDS];

  assign full       = (count_q == CntW'(MAX_RECORDS));
  assign in_acc     = in_valid_i && in_ready_o;
  assign ins        = in_acc && !full;
  assign drain_done = pop && (count_q == CntW'(1));

  assign new_rec.vld = 1'b1;
  assign new_rec.key = in_data_i.sort_key;
  assign new_rec.id  = in_data_i.record_id;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srs_pkg::StLoad: begin
        if (in_acc && in_data_i.last_record) begin
          state_d = srs_pkg::StDrain;
        end
      end
      srs_pkg::StDrain: begin
        if (drain_done) begin
          state_d = srs_pkg::StLoad;
        end
      end
      default: state_d = srs_pkg::StLoad;
    endcase
  end

  // State outputs: accept records while loading, pop the chain head while draining.
  always_comb begin
    in_ready_o = 1'b0;
    pop        = 1'b0;
    unique case (state_q)
      srs_pkg::StLoad: begin
        in_ready_o = 1'b1;
      end
      srs_pkg::StDrain: begin
        pop = !out_vld_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
        pop        = 1'b0;
      end
    endcase
  end

  // Record count and overflow flag for the set in progress.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (ins) begin
      count_d = count_q + CntW'(1);
    end else if (in_acc) begin
      ovf_d = 1'b1;
    end
    if (pop) begin
      count_d = count_q - CntW'(1);
      if (drain_done) begin
        ovf_d = 1'b0;
      end
    end
  end

  // Output register: loaded from the head cell on each pop.
  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (pop) begin
      out_d.sorted_key = cell_rec[0].key;
      out_d.sorted_id  = cell_rec[0].id;
      out_d.last_out   = (count_q == CntW'(1));
      out_d.overflowed = ovf_q;
      out_vld_d        = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= srs_pkg::StLoad;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // The chain of cells, kept in ascending order with empty cells at the tail.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    srs_pkg::cell_rec_t left_rec;
    srs_pkg::cell_rec_t right_rec;
    logic               left_gt;

    if (i == 0) begin : g_head
      assign left_rec = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_inner
      assign right_rec = cell_rec[i+1];
    end

    srs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .new_i      (new_rec),
      .ins_i      (ins),
      .shl_i      (pop),
      .left_rec_i (left_rec),
      .left_gt_i  (left_gt),
      .right_rec_i(right_rec),
      .rec_o      (cell_rec[i]),
      .gt_o       (cell_gt[i])
    );
  end

endmodule

// ===== sim/srs_checker.sv =====
// Scoreboard for the stable record sorter: watches both channels, predicts each sorted set
// and compares every output transaction field by field.
// Depends on srs_pkg for the payload types and the default capacity.
module srs_checker #(
  parameter int unsigned MAX_RECORDS = srs_pkg::MaxRecordsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  srs_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  srs_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            sets_o,
  output int            overflow_sets_o,
  output int            checked_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Records of the set being loaded, in load order, and the drop flag of that set.
  srs_pkg::in_t  held_records[$];
  logic          records_dropped = 1'b0;

  // Sorted records still to come out of the block, oldest first.
  srs_pkg::out_t expected_sorted[$];

  int fail_count    = 0;
  int set_count     = 0;
  int overflow_sets = 0;
  int checked_count = 0;

  // Report one field that differs from its expected value.
  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Stable ordering: each record goes in front of the first record with a larger key,
  // so records with equal keys keep their load order.
  task automatic release_sorted_set();
    srs_pkg::in_t  ordered[$];
    srs_pkg::out_t res;
    int            pos;
    foreach (held_records[r]) begin
      pos = ordered.size();
      for (int j = 0; j < ordered.size(); j++) begin
        if (ordered[j].sort_key > held_records[r].sort_key) begin
          pos = j;
          break;
        end
      end
      ordered.insert(pos, held_records[r]);
    end
    foreach (ordered[k]) begin
      res.sorted_key = ordered[k].sort_key;
      res.sorted_id  = ordered[k].record_id;
      res.last_out   = (k == ordered.size() - 1);
      res.overflowed = records_dropped;
      expected_sorted.push_back(res);
    end
    set_count++;
    if (records_dropped) overflow_sets++;
    held_records.delete();
    records_dropped = 1'b0;
  endtask

  // Store a record while there is room; a full store drops it and marks the set.
  task automatic take_record(input srs_pkg::in_t rec);
    if (held_records.size() < MAX_RECORDS) begin
      held_records.push_back(rec);
    end else begin
      records_dropped = 1'b1;
    end
    if (rec.last_record) release_sorted_set();
  endtask

  // Compare one output transaction with the oldest expectation.
  task automatic check_result(input srs_pkg::out_t got);
    srs_pkg::out_t want;
    if (expected_sorted.size() == 0) begin
      fail_count++;
      $display("%0t ns: unexpected output, expected none, actual %h", $time, got);
    end else begin
      want = expected_sorted.pop_front();
      checked_count++;
      report_field("sorted_key", want.sorted_key, got.sorted_key);
      report_field("sorted_id", 64'(want.sorted_id), 64'(got.sorted_id));
      report_field("last_out", 64'(want.last_out), 64'(got.last_out));
      report_field("overflowed", 64'(want.overflowed), 64'(got.overflowed));
    end
  endtask

  // Sample both channels at each rising edge once reset is released.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) take_record(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
    end
    fail_count_o    <= fail_count;
    pending_o       <= expected_sorted.size();
    sets_o          <= set_count;
    overflow_sets_o <= overflow_sets;
    checked_o       <= checked_count;
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the stable record sorter: clock, reset, record stimulus and verdict.
// Depends on srs_pkg, stable_record_sorter_unit and srs_checker.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 280;
  localparam int SteadyTail  = 40;
  localparam int DrainSlack  = 30;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  srs_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  srs_pkg::out_t out_data_o;

  int    fail_count;
  int    pending;
  int    sets_done;
  int    overflow_sets;
  int    checked;

  // Cleared for the last part of the run, where neither side idles.
  logic  idling_on = 1'b1;
  int    records_sent = 0;

  stable_record_sorter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  srs_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .sets_o          (sets_done),
    .overflow_sets_o (overflow_sets),
    .checked_o       (checked)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pack a course name big-endian into a zero-padded 64-bit key.
  function automatic logic [63:0] pack_name(input string name);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < 8 && i < name.len(); i++) k[63-8*i -: 8] = name[i];
    return k;
  endfunction

  // Random key: full-width values, a small pool that forces ties, course-like names
  // and the two extremes.
  function automatic logic [63:0] random_key();
    logic [63:0] k;
    int          len;
    case ($urandom_range(0, 8))
      0, 1, 2, 3: k = {$urandom, $urandom};
      4, 5: begin
        case ($urandom_range(0, 2))
          0:       k = pack_name("CALCULUS");
          1:       k = pack_name("CHEM");
          default: k = 64'h1;
        endcase
      end
      6, 7: begin
        k   = '0;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) k[63-8*i -: 8] = 8'($urandom_range(65, 90));
      end
      default: k = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return k;
  endfunction

  // Present one record, with an optional idle burst first, and hold it until accepted.
  task automatic send_record(input logic [63:0] key, input logic [9:0] id,
                             input logic last);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    in_data_i.sort_key    <= key;
    in_data_i.record_id   <= id;
    in_data_i.last_record <= last;
    do @(posedge clk_i); while (!in_ready_o);
    records_sent++;
  endtask

  // Send a random set of n records, the final one marked last.
  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) begin
      send_record(random_key(), 10'($urandom_range(0, 1023)), i == n - 1);
    end
  endtask

  // Output side: random stall bursts while idling is on.
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Reset, directed sets, random sets, then drain and verdict.
  initial begin
    int set_idx;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-record sets at both extremes of key and id.
    send_record('1, 10'h3ff, 1'b1);
    send_record('0, 10'h000, 1'b1);

    // Equal keys must keep their load order.
    send_record(pack_name("ALGEBRA"), 10'd5, 1'b0);
    send_record(pack_name("ALGEBRA"), 10'd6, 1'b0);
    send_record(pack_name("ALGEBRA"), 10'd7, 1'b0);
    send_record(pack_name("ALGEBRA"), 10'd8, 1'b1);

    // Names in reverse order, a prefix pair, a tie and both extremes.
    send_record(pack_name("ZOOLOGY"), 10'd100, 1'b0);
    send_record('1, 10'd101, 1'b0);
    send_record(pack_name("ART"), 10'd102, 1'b0);
    send_record(pack_name("ARTS"), 10'd103, 1'b0);
    send_record(pack_name("ART"), 10'd104, 1'b0);
    send_record('0, 10'd105, 1'b1);

    // Keys that differ only in the top or the bottom bit.
    send_record(64'h1, 10'h2aa, 1'b0);
    send_record(64'h8000_0000_0000_0000, 10'h155, 1'b0);
    send_record(64'h0, 10'h3ff, 1'b1);

    // Random sets; a full store, a dropped last record and a drop before the last
    // record are placed early, the rest are small.
    set_idx = 0;
    while (records_sent < ItemTarget) begin
      if (records_sent >= ItemTarget - SteadyTail) idling_on = 1'b0;
      case (set_idx)
        1:       send_random_set(64);
        4:       send_random_set(65);
        7:       send_random_set(66);
        default: send_random_set($urandom_range(1, 12));
      endcase
      set_idx++;
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainSlack) @(posedge clk_i);

    $display("Loaded %0d records in %0d sets, %0d of them with dropped records.",
             records_sent, sets_done, overflow_sets);
    $display("Checked %0d sorted records for order, ids and flags.", checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
